>>> sv/dlpp_pkg.sv
// Package for the display list primitive parser.
// Phase, result kind, error and register codes, and queue sizing.
// No dependencies.
package dlpp_pkg;

  // parse phase within one display list
  typedef enum logic [2:0] {
    PH_CMD     = 3'd0,
    PH_CNT_HI  = 3'd1,
    PH_CNT_LO  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_DRAIN   = 3'd4
  } phase_t;

  // kind of result request
  typedef enum logic [1:0] {
    KIND_PRIM    = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_OPCODE = 3'd1,
    ERR_FORMAT     = 3'd2,
    ERR_HEADER     = 3'd3,
    ERR_PAYLOAD    = 3'd4,
    ERR_NOOP       = 3'd5
  } err_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIST_LENGTH = 1'b0,
    REG_VERTEX_SIZE = 1'b1
  } cfg_reg_t;

  // command byte decode
  localparam logic [7:0] CMD_CLASS_MASK = 8'hC0;
  localparam logic [7:0] CMD_CLASS      = 8'h80;
  localparam logic [7:0] CMD_FMT_MASK   = 8'h07;
  localparam logic [7:0] NOOP_BYTE      = 8'h00;

  localparam logic [7:0] VERTEX_SIZE_RESET = 8'd1;

  // result queue: one push slot per possible result of a byte
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // push controls from the parse core to the result queue
  typedef struct packed {
    logic one;
    logic two;
  } push_t;

endpackage

>>> sv/dlpp_result_queue.sv
// Result queue for the display list primitive parser.
// Takes zero, one or two requests per cycle, delivers one when not stalled; uses dlpp_pkg.
module dlpp_result_queue import dlpp_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic [WIDTH-1:0] wdata0,
  input  logic [WIDTH-1:0] wdata1,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0]  entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] head;
  logic [QPTR_W-1:0] tail;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              pop;
  logic [QPTR_W-1:0] tail_plus1;

  assign out_valid  = (count != '0);
  assign rdata      = entries[head];
  assign pop        = out_valid && !out_stall;
  assign room       = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign tail_plus1 = tail + QPTR_W'(1);

  // occupancy after this cycle's pushes and pop
  always_comb begin
    count_next = count;
    if (push.one) count_next = count_next + QCNT_W'(1);
    if (push.two) count_next = count_next + QCNT_W'(1);
    if (pop)      count_next = count_next - QCNT_W'(1);
  end

  // pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) head <= head + QPTR_W'(1);
      if (push.two)      tail <= tail + QPTR_W'(2);
      else if (push.one) tail <= tail_plus1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push.one) entries[tail]       <= wdata0;
    if (push.two) entries[tail_plus1] <= wdata1;
  end

endmodule

>>> sv/dlpp_core.sv
// Parse core for the display list primitive parser: input register,
// list state, and the per-byte decode that forms up to two results; uses dlpp_pkg.
module dlpp_core import dlpp_pkg::*; #(
  parameter int OFFSET_BITS = 20,
  parameter int RES_W = 2 + 3 + 16 + 4 * OFFSET_BITS + 24 + 3 + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic [OFFSET_BITS-1:0] list_length,
  input  logic [7:0]             vertex_size,
  input  logic                   room,
  output push_t                  push,
  output logic [RES_W-1:0]       res0,
  output logic [RES_W-1:0]       res1
);

  localparam int OB = OFFSET_BITS;
  localparam int W  = ((OB > 24) ? OB : 24) + 2;

  typedef struct packed {
    logic [1:0]    kind;
    logic [2:0]    prim_type;
    logic [15:0]   vertex_count;
    logic [OB-1:0] command_offset;
    logic [OB-1:0] payload_offset;
    logic [23:0]   payload_bytes;
    logic [OB-1:0] trailing_noops;
    logic [OB-1:0] embedded_noops;
    logic [2:0]    error_code;
    logic          last_of_run;
  } res_t;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       fire;

  // list state
  phase_t        phase, phase_next;
  logic [OB-1:0] byte_offset, byte_offset_next;
  logic [7:0]    count_high, count_high_next;
  logic [OB-1:0] cmd_offset_hold, cmd_offset_hold_next;
  logic [2:0]    type_hold, type_hold_next;
  logic [23:0]   payload_left, payload_left_next;
  logic [OB-1:0] noop_total, noop_total_next;
  logic [OB-1:0] last_prim_end, last_prim_end_next;

  // decode terms
  logic [W-1:0]  off_w, ll_w, end_w, pay_end_w, lpe_w, trail_w;
  logic          close, hdr_over, pay_over, noop_bad;
  logic [15:0]   count;
  logic [23:0]   bytes;
  logic [23:0]   pl_dec;
  phase_t        ph_step;
  err_t          step_err;
  logic          rec_valid;
  logic          a_valid, b_valid;
  res_t          a_res, b_res, r0, r1;

  assign fire     = in_full && room;
  assign in_stall = in_full && !room;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_byte <= data_byte;
  end

  // shared arithmetic
  assign off_w     = W'(byte_offset);
  assign ll_w      = W'(list_length);
  assign end_w     = off_w + W'(1);
  assign close     = (end_w >= ll_w);
  assign hdr_over  = ((off_w + W'(3)) > ll_w);
  assign count     = {count_high, in_byte};
  assign bytes     = 24'(vertex_size) * 24'(count);
  assign pay_end_w = end_w + W'(bytes);
  assign pay_over  = (pay_end_w > ll_w);
  assign pl_dec    = (payload_left != '0) ? payload_left - 24'd1 : payload_left;

  // per-byte step: next state and the step result
  always_comb begin
    ph_step              = phase;
    step_err             = ERR_NONE;
    rec_valid            = 1'b0;
    count_high_next      = count_high;
    cmd_offset_hold_next = cmd_offset_hold;
    type_hold_next       = type_hold;
    payload_left_next    = payload_left;
    noop_total_next      = noop_total;
    last_prim_end_next   = last_prim_end;
    case (phase)
      PH_CMD: begin
        if (in_byte == NOOP_BYTE) begin
          noop_total_next = noop_total + OB'(1);
        end else if ((in_byte & CMD_CLASS_MASK) != CMD_CLASS) begin
          step_err = ERR_BAD_OPCODE;
        end else if ((in_byte & CMD_FMT_MASK) != NOOP_BYTE) begin
          step_err = ERR_FORMAT;
        end else if (hdr_over) begin
          step_err = ERR_HEADER;
        end else begin
          type_hold_next       = in_byte[5:3];
          cmd_offset_hold_next = byte_offset;
          ph_step              = PH_CNT_HI;
        end
      end
      PH_CNT_HI: begin
        count_high_next = in_byte;
        ph_step         = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        if (pay_over) begin
          step_err = ERR_PAYLOAD;
        end else begin
          rec_valid          = 1'b1;
          last_prim_end_next = pay_end_w[OB-1:0];
          if (bytes == '0) begin
            ph_step = PH_CMD;
          end else begin
            payload_left_next = bytes;
            ph_step           = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        payload_left_next = pl_dec;
        if (pl_dec == '0) ph_step = PH_CMD;
      end
      default: begin
      end
    endcase
    if (step_err != ERR_NONE) ph_step = PH_DRAIN;
  end

  // end-of-list accounting
  assign lpe_w    = W'(last_prim_end_next);
  assign trail_w  = (end_w >= lpe_w) ? end_w - lpe_w : '0;
  assign noop_bad = (end_w < lpe_w) || (W'(noop_total_next) < trail_w);

  // first candidate: primitive record or step error
  always_comb begin
    a_res   = '0;
    a_valid = rec_valid || (step_err != ERR_NONE);
    if (rec_valid) begin
      a_res.kind           = KIND_PRIM;
      a_res.prim_type      = type_hold;
      a_res.vertex_count   = count;
      a_res.command_offset = cmd_offset_hold;
      a_res.payload_offset = cmd_offset_hold + OB'(3);
      a_res.payload_bytes  = bytes;
    end else begin
      a_res.kind       = KIND_ERROR;
      a_res.error_code = step_err;
    end
  end

  // second candidate: what closing the list gives
  always_comb begin
    b_res   = '0;
    b_valid = close;
    case (ph_step)
      PH_CNT_HI, PH_CNT_LO: begin
        b_res.kind       = KIND_ERROR;
        b_res.error_code = ERR_HEADER;
      end
      PH_PAYLOAD: begin
        b_res.kind       = KIND_ERROR;
        b_res.error_code = ERR_PAYLOAD;
      end
      PH_CMD: begin
        if (noop_bad) begin
          b_res.kind       = KIND_ERROR;
          b_res.error_code = ERR_NOOP;
        end else begin
          b_res.kind           = KIND_SUMMARY;
          b_res.trailing_noops = trail_w[OB-1:0];
          b_res.embedded_noops = noop_total_next - trail_w[OB-1:0];
        end
      end
      default: begin
        b_valid = 1'b0;
      end
    endcase
  end

  // order results and mark the last one
  always_comb begin
    r0 = a_valid ? a_res : b_res;
    r1 = b_res;
    r0.last_of_run = !(a_valid && b_valid);
    r1.last_of_run = 1'b1;
    push.one = fire && (a_valid || b_valid);
    push.two = fire && a_valid && b_valid;
  end

  assign res0 = r0;
  assign res1 = r1;

  // phase and offset after this byte, back to the start when the list closes
  always_comb begin
    phase_next       = ph_step;
    byte_offset_next = end_w[OB-1:0];
    if (close) begin
      phase_next       = PH_CMD;
      byte_offset_next = '0;
    end
  end

  // list state update, cleared when the list closes
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_CMD;
      byte_offset     <= '0;
      count_high      <= '0;
      cmd_offset_hold <= '0;
      type_hold       <= '0;
      payload_left    <= '0;
      noop_total      <= '0;
      last_prim_end   <= '0;
    end else if (fire) begin
      phase       <= phase_next;
      byte_offset <= byte_offset_next;
      if (close) begin
        count_high      <= '0;
        cmd_offset_hold <= '0;
        type_hold       <= '0;
        payload_left    <= '0;
        noop_total      <= '0;
        last_prim_end   <= '0;
      end else begin
        count_high      <= count_high_next;
        cmd_offset_hold <= cmd_offset_hold_next;
        type_hold       <= type_hold_next;
        payload_left    <= payload_left_next;
        noop_total      <= noop_total_next;
        last_prim_end   <= last_prim_end_next;
      end
    end
  end

endmodule

>>> sv/display_list_primitive_parser.sv
// Display list primitive parser, top level: configuration registers,
// parse core and result queue; uses dlpp_pkg, dlpp_core, dlpp_result_queue.
// A byte waits in the input register and is decoded into the queue once the queue
// has room, and a byte giving two results is absorbed by the queue.
// Throughput: one byte per cycle while the queue has room (in_stall otherwise).
// Reset (rst, synchronous): list state cleared, list_length 0, vertex_size 1.
module display_list_primitive_parser import dlpp_pkg::*; #(
  parameter int OFFSET_BITS = 20
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             result_kind,
  output logic [2:0]             prim_type,
  output logic [15:0]            vertex_count,
  output logic [OFFSET_BITS-1:0] command_offset,
  output logic [OFFSET_BITS-1:0] payload_offset,
  output logic [23:0]            payload_bytes,
  output logic [OFFSET_BITS-1:0] trailing_noops,
  output logic [OFFSET_BITS-1:0] embedded_noops,
  output logic [2:0]             error_code,
  output logic                   last_of_run,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [OFFSET_BITS-1:0] cfg_data
);

  localparam int OB    = OFFSET_BITS;
  localparam int RES_W = 2 + 3 + 16 + 4 * OB + 24 + 3 + 1;

  typedef struct packed {
    logic [1:0]    kind;
    logic [2:0]    prim_type;
    logic [15:0]   vertex_count;
    logic [OB-1:0] command_offset;
    logic [OB-1:0] payload_offset;
    logic [23:0]   payload_bytes;
    logic [OB-1:0] trailing_noops;
    logic [OB-1:0] embedded_noops;
    logic [2:0]    error_code;
    logic          last_of_run;
  } res_t;

  logic [OB-1:0]    list_length;
  logic [7:0]       vertex_size;
  logic             room;
  push_t            push;
  logic [RES_W-1:0] res0, res1, head_bits;
  res_t             head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= '0;
      vertex_size <= VERTEX_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIST_LENGTH: list_length <= cfg_data;
        REG_VERTEX_SIZE: vertex_size <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // per-byte parse
  dlpp_core #(
    .OFFSET_BITS(OB),
    .RES_W      (RES_W)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .list_length(list_length),
    .vertex_size(vertex_size),
    .room       (room),
    .push       (push),
    .res0       (res0),
    .res1       (res1)
  );

  // result requests out
  dlpp_result_queue #(
    .WIDTH(RES_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata0   (res0),
    .wdata1   (res1),
    .room     (room),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rdata    (head_bits)
  );

  // unpack the head request onto the ports
  assign head           = head_bits;
  assign result_kind    = head.kind;
  assign prim_type      = head.prim_type;
  assign vertex_count   = head.vertex_count;
  assign command_offset = head.command_offset;
  assign payload_offset = head.payload_offset;
  assign payload_bytes  = head.payload_bytes;
  assign trailing_noops = head.trailing_noops;
  assign embedded_noops = head.embedded_noops;
  assign error_code     = head.error_code;
  assign last_of_run    = head.last_of_run;

endmodule
